>>> rtl/mm64_pkg.sv
// Package for the MurmurHash64A streaming block.
// Holds mixing constants, sequencer state type, xor_shift; no dependencies.
package mm64_pkg;

    localparam logic [63:0] MIX_MULT  = 64'hc6a4a7935bd1e995;
    localparam int unsigned MIX_SHIFT = 47;

    localparam logic [31:0] MIX_MULT_LO = MIX_MULT[31:0];
    localparam logic [31:0] MIX_MULT_HI = MIX_MULT[63:32];

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_MIX,
        ST_TAIL,
        ST_W1,
        ST_W2,
        ST_W3,
        ST_FIN
    } t_state;

    // x ^ (x >> 47)
    function automatic logic [63:0] xor_shift(input logic [63:0] x);
        xor_shift = x ^ (x >> MIX_SHIFT);
    endfunction

endpackage

>>> rtl/mm64_mul.sv
// Iterative 64-bit multiply by the mixing constant, low 64 bits of the product.
// One 32x32 partial product per cycle, three in all; depends on mm64_pkg.
module mm64_mul import mm64_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    output logic        o_done,
    output logic [63:0] o_p
);

    logic [63:0] r_a;
    logic [63:0] r_acc;
    logic [1:0]  r_step;
    logic        r_busy;
    logic        r_done;

    logic [31:0] w_op_x;
    logic [31:0] w_op_y;
    logic [63:0] w_prod;
    logic [63:0] n_acc;

    // step 0: aL*ML, step 1: aL*MH << 32, step 2: aH*ML << 32
    always_comb begin
        w_op_x = (r_step == 2'd2) ? r_a[63:32] : r_a[31:0];
        w_op_y = (r_step == 2'd1) ? MIX_MULT_HI : MIX_MULT_LO;
        w_prod = 64'(w_op_x) * 64'(w_op_y);
        if (r_step == 2'd0) begin
            n_acc = w_prod;
        end else begin
            n_acc = r_acc + {w_prod[31:0], 32'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_step <= 2'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= n_acc;
                if (r_step == 2'd2) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_step <= 2'd0;
                end else begin
                    r_step <= r_step + 2'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule

>>> rtl/murmur64a_hash_64_top.sv
// MurmurHash64A over keys streamed as 64-bit little-endian words.
// Every multiply runs on the one shared multiplier.
// A middle word uses 3 multiplies plus dispatch; a first word adds a seed multiply,
// a last word adds a finalize multiply and a load of the output; a tail word uses 1 multiply.
// Next input is taken once the word is done and its hash has left the park register;
// a stalled output that keeps a hash parked holds the input off.
// Reset (synchronous, active low) clears seed, accumulator, tail count and output valid.
module murmur64a_hash_64_top import mm64_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: hash_seed
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [63:0] i_cfg_data,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [95:0] i_s_tdata,   // [63:0] data_word, [95:64] key_length
    input  logic        i_s_tuser,   // [0] first_word
    input  logic        i_s_tlast,   // last_word
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata    // [63:0] hash_value
);

    t_state r_state, n_state;

    logic [63:0] r_seed;
    logic [63:0] r_acc;
    logic [2:0]  r_tail;
    logic [63:0] r_word;
    logic [2:0]  r_len_lo;
    logic        r_last;
    logic        r_empty;
    logic [63:0] r_hash;
    logic        r_hash_valid;
    logic        r_out_valid;
    logic [63:0] r_out_data;

    logic        w_accept;
    logic        w_mul_start;
    logic [63:0] w_mul_a;
    logic        w_mul_done;
    logic [63:0] w_mul_p;
    logic [63:0] w_tail_word;
    logic        w_out_free;

    assign o_cfg_ready = 1'b1;
    // hold off new work until the sequencer is back at rest and no hash is parked
    assign o_s_tready  = (r_state == ST_IDLE) && !r_hash_valid;
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_out_free  = !r_out_valid || i_m_tready;

    // keep only the low tail bytes of the last word
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            w_tail_word[8*b +: 8] = (3'(b) < r_tail) ? r_word[8*b +: 8] : 8'd0;
        end
    end

    mm64_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .o_done  (w_mul_done),
        .o_p     (w_mul_p)
    );

    // sequencer: next state and multiplier issue
    always_comb begin
        n_state     = r_state;
        w_mul_start = 1'b0;
        w_mul_a     = 64'd0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_s_tuser) begin
                        // seed: length times the mixing constant
                        w_mul_start = 1'b1;
                        w_mul_a     = {32'd0, i_s_tdata[95:64]};
                        n_state     = ST_SEED;
                    end else begin
                        n_state = ST_MIX;
                    end
                end
            end
            ST_SEED: begin
                if (w_mul_done) begin
                    n_state = ST_MIX;
                end
            end
            ST_MIX: begin
                if (r_empty) begin
                    // empty key: mix nothing, finalize only when it is also the last word
                    if (r_last) begin
                        w_mul_start = 1'b1;
                        w_mul_a     = xor_shift(r_acc);
                        n_state     = ST_FIN;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else if (r_last && (r_tail != 3'd0)) begin
                    w_mul_start = 1'b1;
                    w_mul_a     = r_acc ^ w_tail_word;
                    n_state     = ST_TAIL;
                end else begin
                    w_mul_start = 1'b1;
                    w_mul_a     = r_word;
                    n_state     = ST_W1;
                end
            end
            ST_TAIL: begin
                if (w_mul_done) begin
                    w_mul_start = 1'b1;
                    w_mul_a     = xor_shift(w_mul_p);
                    n_state     = ST_FIN;
                end
            end
            ST_W1: begin
                if (w_mul_done) begin
                    w_mul_start = 1'b1;
                    w_mul_a     = xor_shift(w_mul_p);
                    n_state     = ST_W2;
                end
            end
            ST_W2: begin
                if (w_mul_done) begin
                    w_mul_start = 1'b1;
                    w_mul_a     = r_acc ^ w_mul_p;
                    n_state     = ST_W3;
                end
            end
            ST_W3: begin
                if (w_mul_done) begin
                    if (r_last) begin
                        w_mul_start = 1'b1;
                        w_mul_a     = xor_shift(w_mul_p);
                        n_state     = ST_FIN;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FIN: begin
                if (w_mul_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_seed       <= 64'd0;
            r_acc        <= 64'd0;
            r_tail       <= 3'd0;
            r_hash_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                r_seed <= i_cfg_data;
            end

            // capture the word on transfer
            if (w_accept) begin
                r_word   <= i_s_tdata[63:0];
                r_len_lo <= i_s_tdata[66:64];
                r_last   <= i_s_tlast;
                r_empty  <= i_s_tuser && (i_s_tdata[95:64] == 32'd0);
            end

            // update accumulator, tail count or hash when the multiply producing it ends
            if (w_mul_done) begin
                case (r_state)
                    ST_SEED: begin
                        r_acc  <= r_seed ^ w_mul_p;
                        r_tail <= r_len_lo;
                    end
                    ST_TAIL, ST_W3: begin
                        r_acc <= w_mul_p;
                    end
                    ST_FIN: begin
                        r_hash       <= xor_shift(w_mul_p);
                        r_hash_valid <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end

            // move a parked hash into the output register when it frees up
            if (r_hash_valid && w_out_free) begin
                r_out_data   <= r_hash;
                r_out_valid  <= 1'b1;
                r_hash_valid <= 1'b0;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule
